FILE: hw/rtl/ffha_pkg.sv
package ffha_pkg;

  // Heap address width and the field widths that follow from it
  localparam int HEAP_ADDR_BITS = 20;
  localparam int OFF_W          = HEAP_ADDR_BITS;
  localparam int SIZE_W         = HEAP_ADDR_BITS + 1;
  // Adder width: room for a size sum plus a sign bit
  localparam int ALU_W          = SIZE_W + 2;

  localparam logic [SIZE_W-1:0] HEAP_RESET = {1'b1, {OFF_W{1'b0}}};

  typedef enum logic {
    CMD_ALLOC   = 1'b0,
    CMD_RELEASE = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NOFIT   = 2'd1,
    ST_UNKNOWN = 2'd2,
    ST_DOUBLE  = 2'd3
  } status_e;

  // Input item
  typedef struct packed {
    logic              command;
    logic [SIZE_W-1:0] request_bytes;
    logic [OFF_W-1:0]  release_offset;
  } item_t;

  // Result item
  typedef struct packed {
    logic [OFF_W-1:0]  payload_offset;
    logic [1:0]        status;
    logic [SIZE_W-1:0] free_bytes;
  } result_t;

  // One segment table entry
  typedef struct packed {
    logic              used;
    logic [SIZE_W-1:0] size;
    logic [OFF_W-1:0]  start;
  } seg_t;

  localparam int SEG_W = $bits(seg_t);

  // Shared adder request and response
  typedef struct packed {
    logic [ALU_W-1:0] a;
    logic [ALU_W-1:0] b;
    logic             sub;
  } alu_req_t;

  typedef struct packed {
    logic [ALU_W-1:0] sum;
    logic             neg;
    logic             zero;
  } alu_rsp_t;

endpackage

FILE: hw/rtl/ffha_ram.sv
module ffha_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

FILE: hw/rtl/ffha_alu.sv
module ffha_alu import ffha_pkg::*; (
  input  alu_req_t req_i,
  output alu_rsp_t rsp_o
);

  logic [ALU_W-1:0] b_eff;

  // Add, or subtract as add of the complement
  assign b_eff      = req_i.sub ? ~req_i.b : req_i.b;
  assign rsp_o.sum  = req_i.a + b_eff + ALU_W'(req_i.sub);
  assign rsp_o.neg  = req_i.sub & rsp_o.sum[ALU_W-1];
  assign rsp_o.zero = (rsp_o.sum == '0);

endmodule

FILE: hw/rtl/first_fit_heap_allocator_core.sv
// First-fit heap allocator. Keeps an address-ordered segment table in a RAM
// and walks it with one shared adder under a sequencer; busy is high while
// an item is being worked on, and start is taken only when busy is low.
// Each item gives exactly one result, shown for one cycle with done_o, unless
// a heap_bytes write cuts it short; the receiver cannot stall, so results
// must be taken as they come. An allocate scans the table up to the first
// free segment that fits, then grants it with a split (moving later entries
// down to open a slot for the remainder) or grants the whole segment; a
// failed allocate scans every entry. A release scans for the segment, frees
// and merges it, then moves later entries up after a merge. The scan reads
// one table entry per cycle through the RAM read port, which sets the pace,
// and done_o comes in the first cycle with busy low. After reset and after
// each heap_bytes write the block rebuilds the table.
module first_fit_heap_allocator_core import ffha_pkg::*; #(
  parameter int MAX_SEGMENTS = 64,
  parameter int HEADER_BYTES = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [SIZE_W-1:0] cfg_wdata_i,
  input  logic              start,
  input  item_t             item_i,
  output logic              busy,
  output logic              done_o,
  output result_t           result_o
);

  localparam int IDX_W = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
  localparam int CNT_W = $clog2(MAX_SEGMENTS + 1);
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_SEGMENTS);
  localparam logic [ALU_W-1:0] HDR     = ALU_W'(HEADER_BYTES);
  localparam logic [ALU_W-1:0] HDR2    = ALU_W'(2 * HEADER_BYTES);

  typedef enum logic [17:0] {
    S_IDLE   = 18'h00001,
    S_INIT   = 18'h00002,
    S_ASCAN  = 18'h00004,
    S_AGRANT = 18'h00008,
    S_ASUB   = 18'h00010,
    S_ACHK   = 18'h00020,
    S_SHDN   = 18'h00040,
    S_ANEW   = 18'h00080,
    S_AUSED  = 18'h00100,
    S_AHDR   = 18'h00200,
    S_AWHOLE = 18'h00400,
    S_RSCAN  = 18'h00800,
    S_RFREE  = 18'h01000,
    S_RNXT   = 18'h02000,
    S_RPRV   = 18'h04000,
    S_RHDR   = 18'h08000,
    S_RFT    = 18'h10000,
    S_SHUP   = 18'h20000
  } state_e;

  state_e            state_q, state_d;
  logic [SIZE_W-1:0] heap_q;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [SIZE_W-1:0] free_q, free_d;
  logic              done_q, done_d;
  result_t           res_q, res_d;

  logic [IDX_W-1:0]  idx_q, idx_d;
  logic [SIZE_W-1:0] req_q, req_d;
  logic [OFF_W-1:0]  tgt_q, tgt_d;
  logic              tgt_neg_q, tgt_neg_d;
  logic [OFF_W-1:0]  cur_start_q, cur_start_d;
  logic [SIZE_W-1:0] cur_size_q, cur_size_d;
  logic              prev_used_q, prev_used_d;
  logic [SIZE_W-1:0] prev_size_q, prev_size_d;
  logic [OFF_W-1:0]  prev_start_q, prev_start_d;
  logic              nfree_q, nfree_d;
  logic [SIZE_W-1:0] nsize_q, nsize_d;
  logic [SIZE_W-1:0] acc_q, acc_d;
  logic [SIZE_W-1:0] gr_q, gr_d;
  logic [SIZE_W-1:0] rest_q, rest_d;
  logic [IDX_W-1:0]  ptr_q, ptr_d;
  logic [IDX_W-1:0]  src_q, src_d;

  // Table RAM port signals
  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  logic [IDX_W-1:0] ram_raddr;
  seg_t             wseg;
  seg_t             rd;
  logic [SEG_W-1:0] ram_rdata;

  alu_req_t alu_req;
  alu_rsp_t alu_rsp;

  // Derived control values
  logic [SIZE_W-1:0] heap_clamp;
  logic [CNT_W-1:0]  idx_nx;
  logic              pfree;
  logic [1:0]        mrg;
  logic [ALU_W-1:0]  hdr_mrg;
  logic [IDX_W-1:0]  lo;
  logic [OFF_W-1:0]  lo_start;
  logic [CNT_W-1:0]  src0;
  logic              hit;

  ffha_ram #(
    .WIDTH (SEG_W),
    .DEPTH (MAX_SEGMENTS)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (wseg),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  ffha_alu u_alu (
    .req_i (alu_req),
    .rsp_o (alu_rsp)
  );

  assign rd = seg_t'(ram_rdata);

  assign heap_clamp = heap_q[OFF_W] ? HEAP_RESET : heap_q;
  assign idx_nx     = CNT_W'(idx_q) + CNT_W'(1);
  assign pfree      = (idx_q != '0) && !prev_used_q;
  assign mrg        = {1'b0, pfree} + {1'b0, nfree_q};
  assign lo         = pfree ? (idx_q - IDX_W'(1)) : idx_q;
  assign lo_start   = pfree ? prev_start_q : cur_start_q;
  assign src0       = idx_nx + CNT_W'(nfree_q);
  assign hit        = !tgt_neg_q && (rd.start == tgt_q);

  // Header bytes recovered by a merge
  always_comb begin
    case (mrg)
      2'd0:    hdr_mrg = '0;
      2'd1:    hdr_mrg = HDR;
      default: hdr_mrg = HDR2;
    endcase
  end

  assign busy     = (state_q != S_IDLE);
  assign done_o   = done_q;
  assign result_o = res_q;

  // Sequencer
  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    free_d       = free_q;
    done_d       = 1'b0;
    res_d        = res_q;
    idx_d        = idx_q;
    req_d        = req_q;
    tgt_d        = tgt_q;
    tgt_neg_d    = tgt_neg_q;
    cur_start_d  = cur_start_q;
    cur_size_d   = cur_size_q;
    prev_used_d  = prev_used_q;
    prev_size_d  = prev_size_q;
    prev_start_d = prev_start_q;
    nfree_d      = nfree_q;
    nsize_d      = nsize_q;
    acc_d        = acc_q;
    gr_d         = gr_q;
    rest_d       = rest_q;
    ptr_d        = ptr_q;
    src_d        = src_q;
    alu_req      = '0;
    ram_we       = 1'b0;
    ram_waddr    = idx_q;
    ram_raddr    = idx_q + IDX_W'(1);
    wseg         = '0;

    case (state_q)
      // Rebuild the table as one free segment
      S_INIT: begin
        alu_req.a   = ALU_W'(heap_clamp);
        alu_req.b   = HDR;
        alu_req.sub = 1'b1;
        ram_we      = 1'b1;
        ram_waddr   = '0;
        wseg.used   = 1'b0;
        wseg.start  = '0;
        wseg.size   = (alu_rsp.neg || alu_rsp.zero) ? '0 : alu_rsp.sum[SIZE_W-1:0];
        free_d      = wseg.size;
        count_d     = CNT_W'(1);
        state_d     = S_IDLE;
      end

      // Take an item; prime read of entry 0 and form the release target
      S_IDLE: begin
        ram_raddr   = '0;
        alu_req.a   = ALU_W'(item_i.release_offset);
        alu_req.b   = HDR;
        alu_req.sub = 1'b1;
        if (start) begin
          idx_d     = '0;
          req_d     = item_i.request_bytes;
          tgt_d     = alu_rsp.sum[OFF_W-1:0];
          tgt_neg_d = alu_rsp.neg;
          state_d   = (item_i.command == CMD_RELEASE) ? S_RSCAN : S_ASCAN;
        end
      end

      // First-fit scan, one entry per cycle
      S_ASCAN: begin
        alu_req.a   = ALU_W'(rd.size);
        alu_req.b   = ALU_W'(req_q);
        alu_req.sub = 1'b1;
        if (!rd.used && !alu_rsp.neg) begin
          cur_start_d = rd.start;
          cur_size_d  = rd.size;
          state_d     = S_AGRANT;
        end else if (idx_nx == count_q) begin
          done_d               = 1'b1;
          res_d.payload_offset = '0;
          res_d.status         = ST_NOFIT;
          state_d              = S_IDLE;
        end else begin
          idx_d = idx_q + IDX_W'(1);
        end
      end

      S_AGRANT: begin
        alu_req.a = ALU_W'(cur_start_q);
        alu_req.b = HDR;
        gr_d      = alu_rsp.sum[SIZE_W-1:0];
        state_d   = S_ASUB;
      end

      S_ASUB: begin
        alu_req.a   = ALU_W'(cur_size_q);
        alu_req.b   = ALU_W'(req_q);
        alu_req.sub = 1'b1;
        acc_d       = alu_rsp.sum[SIZE_W-1:0];
        state_d     = S_ACHK;
      end

      // Split only if the remainder exceeds a header and the table has room
      S_ACHK: begin
        alu_req.a   = ALU_W'(acc_q);
        alu_req.b   = HDR;
        alu_req.sub = 1'b1;
        if (!alu_rsp.neg && !alu_rsp.zero && (count_q != MAX_CNT)) begin
          rest_d = alu_rsp.sum[SIZE_W-1:0];
          if (count_q != idx_nx) begin
            ptr_d     = count_q[IDX_W-1:0];
            ram_raddr = count_q[IDX_W-1:0] - IDX_W'(1);
            state_d   = S_SHDN;
          end else begin
            state_d = S_ANEW;
          end
        end else begin
          state_d = S_AWHOLE;
        end
      end

      // Move entries down by one to open a slot after the split one
      S_SHDN: begin
        ram_we    = 1'b1;
        ram_waddr = ptr_q;
        wseg      = rd;
        ram_raddr = ptr_q - IDX_W'(2);
        if ((ptr_q - IDX_W'(1)) == (idx_q + IDX_W'(1))) begin
          state_d = S_ANEW;
        end else begin
          ptr_d = ptr_q - IDX_W'(1);
        end
      end

      // Write the free remainder
      S_ANEW: begin
        alu_req.a  = ALU_W'(gr_q);
        alu_req.b  = ALU_W'(req_q);
        ram_we     = 1'b1;
        ram_waddr  = idx_q + IDX_W'(1);
        wseg.used  = 1'b0;
        wseg.size  = rest_q;
        wseg.start = alu_rsp.sum[OFF_W-1:0];
        state_d    = S_AUSED;
      end

      S_AUSED: begin
        alu_req.a   = ALU_W'(free_q);
        alu_req.b   = ALU_W'(req_q);
        alu_req.sub = 1'b1;
        free_d      = alu_rsp.sum[SIZE_W-1:0];
        ram_we      = 1'b1;
        wseg.used   = 1'b1;
        wseg.size   = req_q;
        wseg.start  = cur_start_q;
        state_d     = S_AHDR;
      end

      S_AHDR: begin
        alu_req.a            = ALU_W'(free_q);
        alu_req.b            = HDR;
        alu_req.sub          = 1'b1;
        free_d               = alu_rsp.sum[SIZE_W-1:0];
        count_d              = count_q + CNT_W'(1);
        done_d               = 1'b1;
        res_d.payload_offset = gr_q[OFF_W-1:0];
        res_d.status         = ST_OK;
        state_d              = S_IDLE;
      end

      // Grant the whole segment
      S_AWHOLE: begin
        alu_req.a            = ALU_W'(free_q);
        alu_req.b            = ALU_W'(cur_size_q);
        alu_req.sub          = 1'b1;
        free_d               = alu_rsp.sum[SIZE_W-1:0];
        ram_we               = 1'b1;
        wseg.used            = 1'b1;
        wseg.size            = cur_size_q;
        wseg.start           = cur_start_q;
        done_d               = 1'b1;
        res_d.payload_offset = gr_q[OFF_W-1:0];
        res_d.status         = ST_OK;
        state_d              = S_IDLE;
      end

      // Release scan; the previous entry is kept for merging
      S_RSCAN: begin
        if (hit) begin
          if (!rd.used) begin
            done_d               = 1'b1;
            res_d.payload_offset = '0;
            res_d.status         = ST_DOUBLE;
            state_d              = S_IDLE;
          end else begin
            cur_start_d = rd.start;
            cur_size_d  = rd.size;
            state_d     = S_RFREE;
          end
        end else if (idx_nx == count_q) begin
          done_d               = 1'b1;
          res_d.payload_offset = '0;
          res_d.status         = ST_UNKNOWN;
          state_d              = S_IDLE;
        end else begin
          prev_used_d  = rd.used;
          prev_size_d  = rd.size;
          prev_start_d = rd.start;
          idx_d        = idx_q + IDX_W'(1);
        end
      end

      // Read data now holds the next entry
      S_RFREE: begin
        alu_req.a = ALU_W'(free_q);
        alu_req.b = ALU_W'(cur_size_q);
        free_d    = alu_rsp.sum[SIZE_W-1:0];
        nfree_d   = (idx_nx != count_q) && !rd.used;
        nsize_d   = rd.size;
        acc_d     = cur_size_q;
        state_d   = S_RNXT;
      end

      S_RNXT: begin
        alu_req.a = ALU_W'(acc_q);
        alu_req.b = ALU_W'(nsize_q);
        if (nfree_q) begin
          acc_d = alu_rsp.sum[SIZE_W-1:0];
        end
        state_d = S_RPRV;
      end

      S_RPRV: begin
        alu_req.a = ALU_W'(acc_q);
        alu_req.b = ALU_W'(prev_size_q);
        if (pfree) begin
          acc_d = alu_rsp.sum[SIZE_W-1:0];
        end
        state_d = S_RHDR;
      end

      S_RHDR: begin
        alu_req.a = ALU_W'(acc_q);
        alu_req.b = hdr_mrg;
        acc_d     = alu_rsp.sum[SIZE_W-1:0];
        state_d   = S_RFT;
      end

      // Write the merged segment, then close the gap if any
      S_RFT: begin
        alu_req.a  = ALU_W'(free_q);
        alu_req.b  = hdr_mrg;
        free_d     = alu_rsp.sum[SIZE_W-1:0];
        ram_we     = 1'b1;
        ram_waddr  = lo;
        wseg.used  = 1'b0;
        wseg.size  = acc_q;
        wseg.start = lo_start;
        if ((mrg != 2'd0) && (src0 != count_q)) begin
          src_d     = src0[IDX_W-1:0];
          ptr_d     = lo + IDX_W'(1);
          ram_raddr = src0[IDX_W-1:0];
          state_d   = S_SHUP;
        end else begin
          count_d              = count_q - CNT_W'(mrg);
          done_d               = 1'b1;
          res_d.payload_offset = '0;
          res_d.status         = ST_OK;
          state_d              = S_IDLE;
        end
      end

      // Move entries up over the absorbed ones
      S_SHUP: begin
        ram_we    = 1'b1;
        ram_waddr = ptr_q;
        wseg      = rd;
        ram_raddr = src_q + IDX_W'(1);
        if ((CNT_W'(src_q) + CNT_W'(1)) == count_q) begin
          count_d              = count_q - CNT_W'(mrg);
          done_d               = 1'b1;
          res_d.payload_offset = '0;
          res_d.status         = ST_OK;
          state_d              = S_IDLE;
        end else begin
          src_d = src_q + IDX_W'(1);
          ptr_d = ptr_q + IDX_W'(1);
        end
      end

      default: begin
        state_d = S_INIT;
      end
    endcase

    if (done_d) begin
      res_d.free_bytes = free_d;
    end

    // A heap size write rebuilds the table
    if (cfg_we_i) begin
      state_d = S_INIT;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
      heap_q  <= HEAP_RESET;
      count_q <= CNT_W'(1);
      free_q  <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      free_q  <= free_d;
      done_q  <= done_d;
      if (cfg_we_i) begin
        heap_q <= cfg_wdata_i;
      end
    end
  end

  // Working registers
  always_ff @(posedge clk_i) begin
    res_q        <= res_d;
    idx_q        <= idx_d;
    req_q        <= req_d;
    tgt_q        <= tgt_d;
    tgt_neg_q    <= tgt_neg_d;
    cur_start_q  <= cur_start_d;
    cur_size_q   <= cur_size_d;
    prev_used_q  <= prev_used_d;
    prev_size_q  <= prev_size_d;
    prev_start_q <= prev_start_d;
    nfree_q      <= nfree_d;
    nsize_q      <= nsize_d;
    acc_q        <= acc_d;
    gr_q         <= gr_d;
    rest_q       <= rest_d;
    ptr_q        <= ptr_d;
    src_q        <= src_d;
  end

endmodule

FILE: bench/ffha_heap_checker.sv
module ffha_heap_checker import ffha_pkg::*; #(
  parameter int MAX_SEGMENTS = 64,
  parameter int HEADER_BYTES = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [SIZE_W-1:0] cfg_wdata_i,
  input  logic              start_i,
  input  logic              busy_i,
  input  item_t             item_i,
  input  logic              done_i,
  input  result_t           result_i,
  output int                pending_o,
  output int                errors_o
);

  // Shadow segment table, address ordered
  int unsigned seg_start [MAX_SEGMENTS];
  int unsigned seg_size  [MAX_SEGMENTS];
  bit          seg_used  [MAX_SEGMENTS];
  int unsigned seg_count;
  int unsigned free_sum;

  result_t due_results [$];
  result_t predicted;
  int      fails = 0;

  // Back to one free segment covering the (clamped) heap
  function automatic void rebuild_table(input logic [SIZE_W-1:0] heap_val);
    longint unsigned heap;
    heap = 64'(heap_val);
    if (heap > (64'd1 << HEAP_ADDR_BITS)) heap = 64'd1 << HEAP_ADDR_BITS;
    for (int i = 0; i < MAX_SEGMENTS; i++) begin
      seg_start[i] = 0;
      seg_size[i]  = 0;
      seg_used[i]  = 1'b0;
    end
    seg_size[0] = (heap > HEADER_BYTES) ? int'(heap - HEADER_BYTES) : 0;
    seg_count   = 1;
    free_sum    = seg_size[0];
  endfunction

  // Fold entry k+1 into entry k and close the hole
  function automatic void merge_next(input int unsigned k);
    seg_size[k] += HEADER_BYTES + seg_size[k+1];
    free_sum    += HEADER_BYTES;
    for (int unsigned j = k + 1; j + 1 < seg_count; j++) begin
      seg_start[j] = seg_start[j+1];
      seg_size[j]  = seg_size[j+1];
      seg_used[j]  = seg_used[j+1];
    end
    seg_count--;
  endfunction

  // Apply one request to the table, return the outcome
  function automatic result_t heap_step(input item_t it);
    result_t     r;
    status_e     st;
    int unsigned granted;
    int unsigned req;
    int unsigned sz;
    granted = 0;
    req     = 32'(it.request_bytes);
    if (it.command == CMD_ALLOC) begin
      st = ST_NOFIT;
      for (int unsigned i = 0; i < seg_count; i++) begin
        if (!seg_used[i] && seg_size[i] >= req) begin
          sz          = seg_size[i];
          granted     = seg_start[i] + HEADER_BYTES;
          st          = ST_OK;
          seg_used[i] = 1'b1;
          if (sz > req + HEADER_BYTES && seg_count < MAX_SEGMENTS) begin
            // split: open a slot after i for the remainder
            for (int unsigned j = seg_count; j > i + 1; j--) begin
              seg_start[j] = seg_start[j-1];
              seg_size[j]  = seg_size[j-1];
              seg_used[j]  = seg_used[j-1];
            end
            seg_start[i+1] = granted + req;
            seg_size[i+1]  = sz - req - HEADER_BYTES;
            seg_used[i+1]  = 1'b0;
            seg_size[i]    = req;
            seg_count++;
            free_sum -= req + HEADER_BYTES;
          end else begin
            free_sum -= sz;
          end
          break;
        end
      end
    end else begin
      st = ST_UNKNOWN;
      for (int unsigned i = 0; i < seg_count; i++) begin
        if (seg_start[i] + HEADER_BYTES == it.release_offset) begin
          if (!seg_used[i]) begin
            st = ST_DOUBLE;
          end else begin
            st          = ST_OK;
            seg_used[i] = 1'b0;
            free_sum   += seg_size[i];
            if (i + 1 < seg_count && !seg_used[i+1]) merge_next(i);
            if (i > 0 && !seg_used[i-1]) merge_next(i - 1);
          end
          break;
        end
      end
    end
    r.payload_offset = OFF_W'(granted);
    r.status         = st;
    r.free_bytes     = SIZE_W'(free_sum);
    return r;
  endfunction

  // Compare one returned item against the oldest prediction
  task automatic check_result(input result_t got);
    result_t want;
    if (due_results.size() == 0) begin
      $display("%0t: unexpected result item %p", $time, got);
      fails++;
    end else begin
      want = due_results.pop_front();
      if (got.payload_offset !== want.payload_offset) begin
        $display("%0t: payload_offset expected %0h actual %0h",
                 $time, want.payload_offset, got.payload_offset);
        fails++;
      end
      if (got.status !== want.status) begin
        $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
        fails++;
      end
      if (got.free_bytes !== want.free_bytes) begin
        $display("%0t: free_bytes expected %0h actual %0h",
                 $time, want.free_bytes, got.free_bytes);
        fails++;
      end
    end
  endtask

  // Watch config writes, accepted items and result strobes
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rebuild_table(HEAP_RESET);
      due_results.delete();
      pending_o <= 0;
      errors_o  <= fails;
    end else begin
      if (done_i === 1'b1) check_result(result_i);
      if (cfg_we_i === 1'b1) rebuild_table(cfg_wdata_i);
      if (start_i === 1'b1 && busy_i === 1'b0) begin
        predicted = heap_step(item_i);
        due_results.push_back(predicted);
      end
      pending_o <= due_results.size();
      errors_o  <= fails;
    end
  end

endmodule

FILE: bench/tb_first_fit_heap_allocator_core.sv
module tb_first_fit_heap_allocator_core;
  import ffha_pkg::*;

  localparam int MAX_SEGMENTS = 64;
  localparam int HEADER_BYTES = 16;
  localparam int RESET_CYCLES = 9;
  localparam int SETTLE_CYCLES = 2 * MAX_SEGMENTS + 8;
  localparam int CYCLE_LIMIT = 600000;

  // Random phases: heap size, item count, share of allocates, sizing, idling
  localparam int NUM_PHASES = 7;
  localparam int RANDOM_HEAP_PHASE = 4;
  localparam logic [SIZE_W-1:0] PHASE_HEAP [NUM_PHASES] =
    '{21'h100000, 21'd64, 21'd16, 21'd1024, 21'd0, 21'h1FFFFF, 21'd4096};
  localparam int PHASE_ITEMS [NUM_PHASES] = '{110, 40, 15, 60, 75, 55, 45};
  localparam int PHASE_ALLOC_PCT [NUM_PHASES] = '{90, 55, 50, 55, 60, 65, 60};
  localparam bit PHASE_SMALL [NUM_PHASES] = '{1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0};
  localparam bit PHASE_IDLE [NUM_PHASES] = '{1'b0, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1};

  logic              clk_i;
  logic              rst_ni    = 1'b0;
  logic              cfg_we    = 1'b0;
  logic [SIZE_W-1:0] cfg_wdata = '0;
  logic              start     = 1'b0;
  item_t             item      = '0;
  logic              busy;
  logic              done;
  result_t           result;
  int                pending;
  int                errors;
  int unsigned       cycles = 0;

  // Stimulus bookkeeping: live grants, recently released, commands in flight
  int unsigned       heap_now = 32'(HEAP_RESET);
  logic [OFF_W-1:0]  live_offs [$];
  logic [OFF_W-1:0]  freed_offs [$];
  cmd_e              issued_cmds [$];
  cmd_e              done_cmd;
  int                burst_left = 0;

  first_fit_heap_allocator_core #(
    .MAX_SEGMENTS(MAX_SEGMENTS),
    .HEADER_BYTES(HEADER_BYTES)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata),
    .start      (start),
    .item_i     (item),
    .busy       (busy),
    .done_o     (done),
    .result_o   (result)
  );

  ffha_heap_checker #(
    .MAX_SEGMENTS(MAX_SEGMENTS),
    .HEADER_BYTES(HEADER_BYTES)
  ) u_heap_check (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata),
    .start_i    (start),
    .busy_i     (busy),
    .item_i     (item),
    .done_i     (done),
    .result_i   (result),
    .pending_o  (pending),
    .errors_o   (errors)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Run limit
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("first_fit_heap_allocator_core test failed");
      $finish;
    end
  end

  // Collect granted offsets so later releases can name real payloads
  always @(posedge clk_i) begin
    if (rst_ni && done === 1'b1 && issued_cmds.size() > 0) begin
      done_cmd = issued_cmds.pop_front();
      if (done_cmd == CMD_ALLOC && result.status == ST_OK) live_offs.push_back(result.payload_offset);
    end
  end

  function automatic item_t alloc_item(input logic [SIZE_W-1:0] n);
    item_t it;
    it.command        = CMD_ALLOC;
    it.request_bytes  = n;
    it.release_offset = OFF_W'($urandom);
    return it;
  endfunction

  function automatic item_t release_item(input logic [OFF_W-1:0] off);
    item_t it;
    it.command        = CMD_RELEASE;
    it.request_bytes  = SIZE_W'($urandom);
    it.release_offset = off;
    return it;
  endfunction

  // Mostly small requests, some up to the heap, a few beyond any fit
  function automatic logic [SIZE_W-1:0] pick_request(input bit small_only);
    int r;
    r = $urandom_range(0, 99);
    if (small_only) return SIZE_W'($urandom_range(0, 64));
    if (r < 5)  return '0;
    if (r < 45) return SIZE_W'($urandom_range(1, 32));
    if (r < 70) return SIZE_W'($urandom_range(0, 256));
    if (r < 82) return SIZE_W'($urandom_range(0, heap_now / 4));
    if (r < 92) return SIZE_W'($urandom_range(0, heap_now));
    if (r < 97) return SIZE_W'($urandom);
    return ($urandom_range(0, 1) == 0) ? {SIZE_W{1'b1}} : HEAP_RESET;
  endfunction

  // Mostly live payloads; some double releases, misaligned and wild offsets
  function automatic logic [OFF_W-1:0] pick_release();
    int               r;
    int               k;
    logic [OFF_W-1:0] off;
    r = $urandom_range(0, 99);
    if (r < 75 && live_offs.size() > 0) begin
      k   = $urandom_range(0, live_offs.size() - 1);
      off = live_offs[k];
      live_offs.delete(k);
      freed_offs.push_back(off);
      if (freed_offs.size() > 8) void'(freed_offs.pop_front());
    end else if (r < 85 && freed_offs.size() > 0) begin
      off = freed_offs[$urandom_range(0, freed_offs.size() - 1)];
    end else if (r < 92 && live_offs.size() > 0) begin
      off = live_offs[$urandom_range(0, live_offs.size() - 1)] + OFF_W'($urandom_range(1, 15));
    end else begin
      off = OFF_W'($urandom);
    end
    return off;
  endfunction

  // Bursts of back-to-back items, then a gap of random length
  function automatic int next_gap(input bit idling);
    int r;
    if (!idling) return 0;
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    burst_left = $urandom_range(0, 23);
    r = $urandom_range(0, 99);
    if (r < 50) return $urandom_range(1, 8);
    if (r < 85) return $urandom_range(9, 80);
    return $urandom_range(81, 200);
  endfunction

  // Hold start until the item is taken, then idle for the given gap
  task automatic send_item(input item_t it, input int gap);
    start <= 1'b1;
    item  <= it;
    do @(posedge clk_i); while (busy !== 1'b0);
    issued_cmds.push_back(cmd_e'(it.command));
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Wait until every predicted result has come back and the block is idle
  task automatic drain_results();
    start <= 1'b0;
    do @(posedge clk_i); while (pending != 0 || busy !== 1'b0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_heap(input logic [SIZE_W-1:0] v);
    drain_results();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
    live_offs.delete();
    freed_offs.delete();
    heap_now = 32'((v > HEAP_RESET) ? HEAP_RESET : v);
  endtask

  initial begin
    item_t             it;
    int                r;
    logic [SIZE_W-1:0] heap_val;

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset heap: split, reject, release, double release, reuse, merge
    send_item(alloc_item(21'd0), $urandom_range(0, 3));
    send_item(alloc_item(21'd100), $urandom_range(0, 3));
    send_item(alloc_item(21'd50), $urandom_range(0, 3));
    send_item(alloc_item({SIZE_W{1'b1}}), $urandom_range(0, 3));
    send_item(alloc_item(HEAP_RESET), $urandom_range(0, 3));
    send_item(release_item(20'd32), $urandom_range(0, 3));
    send_item(release_item(20'd32), $urandom_range(0, 3));
    send_item(release_item(20'd0), $urandom_range(0, 3));
    send_item(release_item({OFF_W{1'b1}}), $urandom_range(0, 3));
    send_item(alloc_item(21'd100), $urandom_range(0, 3));
    send_item(release_item(20'd148), $urandom_range(0, 3));
    send_item(release_item(20'd32), $urandom_range(0, 3));
    send_item(release_item(20'd16), $urandom_range(0, 3));

    // Heap no bigger than a header: one empty segment
    set_heap('0);
    send_item(alloc_item(21'd0), 0);
    send_item(alloc_item(21'd1), 0);
    send_item(release_item(20'd16), 0);

    // Oversized heap gets clamped; take it whole
    set_heap({SIZE_W{1'b1}});
    send_item(alloc_item(SIZE_W'(HEAP_RESET - HEADER_BYTES)), 1);
    send_item(release_item(20'd16), 1);

    // Smallest useful heap: one split, then a grant without split
    set_heap(21'd64);
    send_item(alloc_item(21'd16), 2);
    send_item(alloc_item(21'd16), 2);
    send_item(alloc_item(21'd0), 2);

    // Random phases over several heap sizes
    for (int p = 0; p < NUM_PHASES; p++) begin
      heap_val = (p == RANDOM_HEAP_PHASE) ? SIZE_W'($urandom_range(64, HEAP_RESET))
                                          : PHASE_HEAP[p];
      set_heap(heap_val);
      burst_left = 0;
      for (int n = 0; n < PHASE_ITEMS[p]; n++) begin
        r = $urandom_range(0, 99);
        if (r < PHASE_ALLOC_PCT[p]) it = alloc_item(pick_request(PHASE_SMALL[p]));
        else it = release_item(pick_release());
        send_item(it, next_gap(PHASE_IDLE[p]));
      end
    end

    drain_results();
    if (errors == 0 && pending == 0) begin
      $display("first_fit_heap_allocator_core test passed");
    end else begin
      $display("first_fit_heap_allocator_core test failed");
    end
    $finish;
  end

endmodule
